// File: hw/rtl/tccs_pkg.sv
// Package of the text console character statistics block.
// Holds the character codes, register indexes, action codes and the job and
// result records shared by the front, the job queue and the back. No dependencies.
package tccs_pkg;

  localparam int unsigned OUT_CNT_W  = 20;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_ADVANCE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 8'd3;

  localparam logic [9:0] AREA_WIDTH_RST    = 10'd319;
  localparam logic [8:0] AREA_HEIGHT_RST   = 9'd479;
  localparam logic [5:0] GLYPH_ADVANCE_RST = 6'd11;
  localparam logic [6:0] LINE_PITCH_RST    = 7'd22;

  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] reads;
    logic [OUT_CNT_W-1:0] writes;
    logic [OUT_CNT_W-1:0] digits;
    logic [OUT_CNT_W-1:0] uppers;
    logic [OUT_CNT_W-1:0] lowers;
    logic [OUT_CNT_W-1:0] words;
  } cnt_t;

  // One classified byte; clear_next marks a glyph whose line wrap clears the area.
  typedef struct packed {
    action_e    action;
    logic [7:0] code;
    logic [9:0] x;
    logic [8:0] y;
    logic       clear_next;
    cnt_t       cnt;
  } job_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] code;
    logic [9:0] x;
    logic [8:0] y;
    logic       last;
    cnt_t       cnt;
  } res_t;

endpackage

// File: hw/rtl/tccs_front.sv
// Front part: configuration registers, byte classification, saturating counters
// and text cursor. Emits one job record per accepted byte. Depends on tccs_pkg.
module tccs_front #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tccs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push_i,
  input  logic [7:0]                      rx_byte_i,
  output tccs_pkg::job_t                  job_o
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [9:0] area_width_q;
  logic [8:0] area_height_q;
  logic [5:0] glyph_advance_q;
  logic [6:0] line_pitch_q;

  logic [9:0] cursor_x_q, cursor_x_d;
  logic [8:0] cursor_y_q, cursor_y_d;
  logic [7:0] prev_q;

  logic [COUNT_WIDTH-1:0] reads_q, reads_d, writes_q, writes_d;
  logic [COUNT_WIDTH-1:0] digits_q, digits_d, uppers_q, uppers_d;
  logic [COUNT_WIDTH-1:0] lowers_q, lowers_d, spaces_q, spaces_d;
  logic [COUNT_WIDTH-1:0] words_q, words_d;

  logic        is_digit, is_lower, is_upper, is_space_run, is_newline;
  logic [9:0]  y_step;
  logic [10:0] y_test;
  logic [10:0] x_test;
  logic        screen_wrap, line_wrap;
  logic [8:0]  y_line;

  always_comb begin
    is_digit     = (rx_byte_i >= tccs_pkg::CH_ZERO) && (rx_byte_i <= tccs_pkg::CH_NINE);
    is_lower     = (rx_byte_i >= tccs_pkg::CH_LOWER_A) && (rx_byte_i <= tccs_pkg::CH_LOWER_Z);
    is_upper     = (rx_byte_i >= tccs_pkg::CH_UPPER_A) && (rx_byte_i <= tccs_pkg::CH_UPPER_Z);
    is_space_run = (rx_byte_i == tccs_pkg::CH_SPACE) && (prev_q != tccs_pkg::CH_SPACE);
    is_newline   = (rx_byte_i == tccs_pkg::CH_NEWLINE);

    reads_d  = (reads_q != CNT_MAX) ? reads_q + 1'b1 : reads_q;
    writes_d = (!is_newline && writes_q != CNT_MAX) ? writes_q + 1'b1 : writes_q;
    digits_d = (is_digit && digits_q != CNT_MAX) ? digits_q + 1'b1 : digits_q;
    lowers_d = (is_lower && lowers_q != CNT_MAX) ? lowers_q + 1'b1 : lowers_q;
    uppers_d = (is_upper && uppers_q != CNT_MAX) ? uppers_q + 1'b1 : uppers_q;
    spaces_d = (is_space_run && spaces_q != CNT_MAX) ? spaces_q + 1'b1 : spaces_q;
    words_d  = words_q;
    if (is_space_run) begin
      words_d = (spaces_d != CNT_MAX) ? spaces_d + 1'b1 : spaces_d;
    end

    // A line step lands at row + pitch unless the next line would pass the bottom.
    y_step      = {1'b0, cursor_y_q} + {3'b000, line_pitch_q};
    y_test      = {1'b0, y_step} + {4'b0000, line_pitch_q};
    screen_wrap = y_test > {2'b00, area_height_q};
    y_line      = screen_wrap ? 9'd0 : y_step[8:0];
    x_test      = {1'b0, cursor_x_q} + {4'b0000, line_pitch_q};
    line_wrap   = x_test > {1'b0, area_width_q};

    job_o.code       = 8'd0;
    job_o.x          = 10'd0;
    job_o.y          = 9'd0;
    job_o.clear_next = 1'b0;
    if (is_newline) begin
      job_o.action = screen_wrap ? tccs_pkg::ACT_CLEAR : tccs_pkg::ACT_NONE;
      cursor_x_d   = 10'd0;
      cursor_y_d   = y_line;
    end else begin
      job_o.action = tccs_pkg::ACT_DRAW;
      job_o.code   = rx_byte_i;
      job_o.x      = cursor_x_q;
      job_o.y      = cursor_y_q;
      if (line_wrap) begin
        job_o.clear_next = screen_wrap;
        cursor_x_d       = 10'd0;
        cursor_y_d       = y_line;
      end else begin
        cursor_x_d = cursor_x_q + {4'b0000, glyph_advance_q};
        cursor_y_d = cursor_y_q;
      end
    end

    job_o.cnt.reads  = tccs_pkg::OUT_CNT_W'(reads_d);
    job_o.cnt.writes = tccs_pkg::OUT_CNT_W'(writes_d);
    job_o.cnt.digits = tccs_pkg::OUT_CNT_W'(digits_d);
    job_o.cnt.uppers = tccs_pkg::OUT_CNT_W'(uppers_d);
    job_o.cnt.lowers = tccs_pkg::OUT_CNT_W'(lowers_d);
    job_o.cnt.words  = tccs_pkg::OUT_CNT_W'(words_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_width_q    <= tccs_pkg::AREA_WIDTH_RST;
      area_height_q   <= tccs_pkg::AREA_HEIGHT_RST;
      glyph_advance_q <= tccs_pkg::GLYPH_ADVANCE_RST;
      line_pitch_q    <= tccs_pkg::LINE_PITCH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tccs_pkg::REG_AREA_WIDTH:    area_width_q    <= cfg_data_i[9:0];
        tccs_pkg::REG_AREA_HEIGHT:   area_height_q   <= cfg_data_i[8:0];
        tccs_pkg::REG_GLYPH_ADVANCE: glyph_advance_q <= cfg_data_i[5:0];
        tccs_pkg::REG_LINE_PITCH:    line_pitch_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= 10'd1;
      cursor_y_q <= 9'd1;
      prev_q     <= 8'd0;
      reads_q    <= '0;
      writes_q   <= '0;
      digits_q   <= '0;
      uppers_q   <= '0;
      lowers_q   <= '0;
      spaces_q   <= '0;
      words_q    <= '0;
    end else if (push_i) begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      prev_q     <= rx_byte_i;
      reads_q    <= reads_d;
      writes_q   <= writes_d;
      digits_q   <= digits_d;
      uppers_q   <= uppers_d;
      lowers_q   <= lowers_d;
      spaces_q   <= spaces_d;
      words_q    <= words_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_o.clear_next |-> (job_o.action == tccs_pkg::ACT_DRAW))
    else $error("clear follow-up flagged on a job that draws no glyph");

endmodule

// File: hw/rtl/tccs_job_fifo.sv
// Two-entry queue of job records between the front and the back.
// Depends on tccs_pkg.
module tccs_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tccs_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tccs_pkg::job_t job_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tccs_pkg::job_t   entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("job queue holds more entries than it has");

endmodule

// File: hw/rtl/tccs_back.sv
// Back part: turns each job into one or two results and holds the oldest
// result in an output register until it is taken. Depends on tccs_pkg.
module tccs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_empty_i,
  input  tccs_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tccs_pkg::res_t res_o
);

  tccs_pkg::res_t out_q, out_d;
  logic           out_valid_q, out_valid_d;
  logic           pend_q, pend_d;
  logic           slot_free;

  always_comb begin
    slot_free   = !out_valid_q || pop_i;
    job_pop_o   = slot_free && !pend_q && !job_empty_i;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    pend_d      = pend_q;
    if (slot_free) begin
      if (pend_q) begin
        // The clear request after a wrapped glyph keeps the glyph's counters.
        out_d.action = tccs_pkg::ACT_CLEAR;
        out_d.code   = 8'd0;
        out_d.x      = 10'd0;
        out_d.y      = 9'd0;
        out_d.last   = 1'b1;
        out_valid_d  = 1'b1;
        pend_d       = 1'b0;
      end else if (!job_empty_i) begin
        out_d.action = job_i.action;
        out_d.code   = job_i.code;
        out_d.x      = job_i.x;
        out_d.y      = job_i.y;
        out_d.last   = !job_i.clear_next;
        out_d.cnt    = job_i.cnt;
        out_valid_d  = 1'b1;
        pend_d       = job_i.clear_next;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (out_valid_q && !out_q.last && out_q.action == tccs_pkg::ACT_DRAW))
    else $error("pending clear without a wrapped glyph on the output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && out_valid_q && pend_q) |=>
      (out_valid_q && out_q.last && out_q.action == tccs_pkg::ACT_CLEAR))
    else $error("clear request did not follow its wrapped glyph");

endmodule

// File: hw/rtl/text_console_char_statistics.sv
// Top level of the text console character statistics block.
// Usage:
//   Input bytes enter through push/full; a byte is taken at a clock edge with
//   push high and full low. Results leave through empty/pop; the oldest result
//   sits on the result ports while empty is low and is taken with pop.
//   Each byte gives one result, or two when a glyph wraps past the bottom of the
//   area (draw request with last low, then a clear request with last high).
//   Registers are written through cfg_valid_i/cfg_ready_o, by the user only while the
//   block is idle (not enforced); cfg_ready_o is always high, unknown indexes dropped.
// Timing:
//   The front classifies a byte and updates counters and cursor in the cycle
//   it is taken, so a new byte can be pushed every cycle while full is low. The
//   back drains one result per cycle while pop is high; a result passes the job
//   queue and then the output register. Sustained rate is one byte per cycle for
//   one-result bytes; a wrapping glyph also holds the single output register for
//   its clear request. With pop held low the two-entry job queue fills and full rises.
// Reset:
//   Registers return to their defaults, cursor to (1,1), counters to zero and
//   all queues empty. Depends on tccs_pkg, tccs_front, tccs_job_fifo, tccs_back.
module text_console_char_statistics #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tccs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      rx_byte_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      action_o,
  output logic [7:0]                      glyph_code_o,
  output logic [9:0]                      glyph_x_o,
  output logic [8:0]                      glyph_y_o,
  output logic                            last_o,
  output logic [tccs_pkg::OUT_CNT_W-1:0]  read_count_o,
  output logic [tccs_pkg::OUT_CNT_W-1:0]  write_count_o,
  output logic [tccs_pkg::OUT_CNT_W-1:0]  digit_count_o,
  output logic [tccs_pkg::OUT_CNT_W-1:0]  upper_count_o,
  output logic [tccs_pkg::OUT_CNT_W-1:0]  lower_count_o,
  output logic [tccs_pkg::OUT_CNT_W-1:0]  word_count_o
);

  tccs_pkg::job_t front_job, queue_job;
  tccs_pkg::res_t res;
  logic           accept, queue_empty, queue_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  tccs_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (accept),
    .rx_byte_i   (rx_byte_i),
    .job_o       (front_job)
  );

  tccs_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .job_o   (queue_job)
  );

  tccs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (queue_empty),
    .job_i       (queue_job),
    .job_pop_o   (queue_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign action_o      = res.action;
  assign glyph_code_o  = res.code;
  assign glyph_x_o     = res.x;
  assign glyph_y_o     = res.y;
  assign last_o        = res.last;
  assign read_count_o  = res.cnt.reads;
  assign write_count_o = res.cnt.writes;
  assign digit_count_o = res.cnt.digits;
  assign upper_count_o = res.cnt.uppers;
  assign lower_count_o = res.cnt.lowers;
  assign word_count_o  = res.cnt.words;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the text console character statistics block.
// Drives bytes and register writes into text_console_char_statistics, predicts every
// draw and clear request with its counters, and compares them. Depends on tccs_pkg.
module testbench;

  localparam int unsigned CNT_W = 20;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;
  localparam longint unsigned TIME_LIMIT = 10_000_000;

  class console_predictor;
    int unsigned area_w, area_h, advance, pitch;
    int unsigned cur_x, cur_y;
    logic [7:0] prev_byte;
    longint unsigned reads, writes, digits, uppers, lowers, spaces, words;
    tccs_pkg::res_t due_results[$];
    int unsigned mismatches;

    function new();
      area_w = tccs_pkg::AREA_WIDTH_RST;
      area_h = tccs_pkg::AREA_HEIGHT_RST;
      advance = tccs_pkg::GLYPH_ADVANCE_RST;
      pitch = tccs_pkg::LINE_PITCH_RST;
      cur_x = 1;
      cur_y = 1;
      prev_byte = '0;
      reads = 0;
      writes = 0;
      digits = 0;
      uppers = 0;
      lowers = 0;
      spaces = 0;
      words = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic [tccs_pkg::CFG_IDX_W-1:0] idx,
                               logic [tccs_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tccs_pkg::REG_AREA_WIDTH: area_w = data[9:0];
        tccs_pkg::REG_AREA_HEIGHT: area_h = data[8:0];
        tccs_pkg::REG_GLYPH_ADVANCE: advance = data[5:0];
        tccs_pkg::REG_LINE_PITCH: pitch = data[6:0];
        default: ;
      endcase
    endfunction

    function longint unsigned bump(longint unsigned v);
      return (v >= CNT_MAX) ? CNT_MAX : v + 1;
    endfunction

    // Moves the cursor to the next line and tells whether the area must be cleared.
    function bit line_feed();
      cur_x = 0;
      cur_y = cur_y + pitch;
      if (cur_y + pitch > area_h) begin
        cur_y = 0;
        return 1'b1;
      end
      cur_y = cur_y & 'h1FF;
      return 1'b0;
    endfunction

    function void queue_result(tccs_pkg::action_e act, logic [7:0] code, int unsigned x,
                               int unsigned y, bit last);
      tccs_pkg::res_t r;
      r.action = act;
      r.code = code;
      r.x = x[9:0];
      r.y = y[8:0];
      r.last = last;
      r.cnt.reads = reads[tccs_pkg::OUT_CNT_W-1:0];
      r.cnt.writes = writes[tccs_pkg::OUT_CNT_W-1:0];
      r.cnt.digits = digits[tccs_pkg::OUT_CNT_W-1:0];
      r.cnt.uppers = uppers[tccs_pkg::OUT_CNT_W-1:0];
      r.cnt.lowers = lowers[tccs_pkg::OUT_CNT_W-1:0];
      r.cnt.words = words[tccs_pkg::OUT_CNT_W-1:0];
      due_results.push_back(r);
    endfunction

    function void predict_byte(logic [7:0] b);
      int unsigned gx, gy;
      bit wrap;
      if (b >= tccs_pkg::CH_ZERO && b <= tccs_pkg::CH_NINE) begin
        digits = bump(digits);
      end else if (b >= tccs_pkg::CH_LOWER_A && b <= tccs_pkg::CH_LOWER_Z) begin
        lowers = bump(lowers);
      end else if (b >= tccs_pkg::CH_UPPER_A && b <= tccs_pkg::CH_UPPER_Z) begin
        uppers = bump(uppers);
      end else if (b == tccs_pkg::CH_SPACE && prev_byte != tccs_pkg::CH_SPACE) begin
        spaces = bump(spaces);
        words = bump(spaces);
      end
      reads = bump(reads);
      if (b == tccs_pkg::CH_NEWLINE) begin
        wrap = line_feed();
        prev_byte = b;
        queue_result(wrap ? tccs_pkg::ACT_CLEAR : tccs_pkg::ACT_NONE, '0, 0, 0, 1'b1);
        return;
      end
      writes = bump(writes);
      gx = cur_x;
      gy = cur_y;
      wrap = 1'b0;
      if (cur_x + pitch > area_w) begin
        wrap = line_feed();
      end else begin
        cur_x = (cur_x + advance) & 'h3FF;
      end
      prev_byte = b;
      queue_result(tccs_pkg::ACT_DRAW, b, gx, gy, !wrap);
      if (wrap) begin
        queue_result(tccs_pkg::ACT_CLEAR, '0, 0, 0, 1'b1);
      end
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(tccs_pkg::res_t got);
      tccs_pkg::res_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected request: expected none, actual action %0d code %0d",
                 $time, got.action, got.code);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      check_field("action", want.action, got.action);
      check_field("glyph_code", want.code, got.code);
      check_field("glyph_x", want.x, got.x);
      check_field("glyph_y", want.y, got.y);
      check_field("last", want.last, got.last);
      check_field("read_count", want.cnt.reads, got.cnt.reads);
      check_field("write_count", want.cnt.writes, got.cnt.writes);
      check_field("digit_count", want.cnt.digits, got.cnt.digits);
      check_field("upper_count", want.cnt.uppers, got.cnt.uppers);
      check_field("lower_count", want.cnt.lowers, got.cnt.lowers);
      check_field("word_count", want.cnt.words, got.cnt.words);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [tccs_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic push;
  logic full;
  logic [7:0] rx_byte_i;
  logic empty;
  logic pop;
  logic [1:0] action_o;
  logic [7:0] glyph_code_o;
  logic [9:0] glyph_x_o;
  logic [8:0] glyph_y_o;
  logic last_o;
  logic [tccs_pkg::OUT_CNT_W-1:0] read_count_o;
  logic [tccs_pkg::OUT_CNT_W-1:0] write_count_o;
  logic [tccs_pkg::OUT_CNT_W-1:0] digit_count_o;
  logic [tccs_pkg::OUT_CNT_W-1:0] upper_count_o;
  logic [tccs_pkg::OUT_CNT_W-1:0] lower_count_o;
  logic [tccs_pkg::OUT_CNT_W-1:0] word_count_o;

  console_predictor board = new();
  bit push_calm;

  logic [7:0] boundary_bytes [24] = '{
    8'h00, 8'hFF, tccs_pkg::CH_NEWLINE, tccs_pkg::CH_SPACE, tccs_pkg::CH_SPACE, 8'd47,
    tccs_pkg::CH_ZERO, tccs_pkg::CH_NINE, 8'd58, 8'd64, tccs_pkg::CH_UPPER_A,
    tccs_pkg::CH_UPPER_Z, 8'd91, 8'd96, tccs_pkg::CH_LOWER_A, tccs_pkg::CH_LOWER_Z,
    8'd123, 8'd127, 8'd128, tccs_pkg::CH_SPACE, tccs_pkg::CH_NEWLINE,
    tccs_pkg::CH_NEWLINE, 8'h55, 8'hAA
  };

  text_console_char_statistics #(
    .COUNT_WIDTH(CNT_W)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .push(push),
    .full(full),
    .rx_byte_i(rx_byte_i),
    .empty(empty),
    .pop(pop),
    .action_o(action_o),
    .glyph_code_o(glyph_code_o),
    .glyph_x_o(glyph_x_o),
    .glyph_y_o(glyph_y_o),
    .last_o(last_o),
    .read_count_o(read_count_o),
    .write_count_o(write_count_o),
    .digit_count_o(digit_count_o),
    .upper_count_o(upper_count_o),
    .lower_count_o(lower_count_o),
    .word_count_o(word_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Idle stretches alternate with runs that have no idling at all.
  function automatic int unsigned next_gap(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return 8'($urandom_range(tccs_pkg::CH_LOWER_A, tccs_pkg::CH_LOWER_Z));
    if (roll < 40) return 8'($urandom_range(tccs_pkg::CH_UPPER_A, tccs_pkg::CH_UPPER_Z));
    if (roll < 50) return 8'($urandom_range(tccs_pkg::CH_ZERO, tccs_pkg::CH_NINE));
    if (roll < 65) return tccs_pkg::CH_SPACE;
    if (roll < 75) return tccs_pkg::CH_NEWLINE;
    return 8'($urandom);
  endfunction

  always @(posedge clk_i) begin : monitor
    tccs_pkg::res_t seen;
    if (cfg_valid_i && cfg_ready_o) board.set_register(cfg_index_i, cfg_data_i);
    if (push && !full) board.predict_byte(rx_byte_i);
    if (pop && !empty) begin
      seen.action = tccs_pkg::action_e'(action_o);
      seen.code = glyph_code_o;
      seen.x = glyph_x_o;
      seen.y = glyph_y_o;
      seen.last = last_o;
      seen.cnt.reads = read_count_o;
      seen.cnt.writes = write_count_o;
      seen.cnt.digits = digit_count_o;
      seen.cnt.uppers = upper_count_o;
      seen.cnt.lowers = lower_count_o;
      seen.cnt.words = word_count_o;
      board.check_result(seen);
    end
  end

  initial begin : result_sink
    int unsigned gap;
    bit calm;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    pop <= 1'b1;
    forever begin
      do @(posedge clk_i); while (empty !== 1'b0);
      gap = next_gap(calm);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
        pop <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = next_gap(push_calm);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full !== 1'b0);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_byte(pick_byte());
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic write_reg(input logic [tccs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tccs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
  endtask

  // Upper data bits beyond each register's width are filled with noise.
  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned a, input int unsigned p);
    write_reg(tccs_pkg::REG_AREA_WIDTH, {6'($urandom), w[9:0]});
    write_reg(tccs_pkg::REG_AREA_HEIGHT, {7'($urandom), h[8:0]});
    write_reg(8'($urandom_range(4, 255)), 16'($urandom));
    write_reg(tccs_pkg::REG_GLYPH_ADVANCE, {10'($urandom), a[5:0]});
    write_reg(tccs_pkg::REG_LINE_PITCH, {9'($urandom), p[6:0]});
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    rst_ni <= 1'b0;
    push <= 1'b0;
    rx_byte_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (boundary_bytes[i]) send_byte(boundary_bytes[i]);
    send_random(60);
    drain();
    configure(640, 480, 32, 64);
    send_random(100);
    drain();
    configure(22, 22, 1, 1);
    send_random(100);
    drain();
    // Zero line pitch with the widest area lets the column wrap around past 1023.
    configure(1023, 511, 63, 0);
    send_random(60);
    drain();
    configure(0, 0, 0, 127);
    send_random(40);
    drain();
    repeat (4) begin
      configure($urandom_range(22, 640), $urandom_range(22, 480),
                $urandom_range(1, 32), $urandom_range(1, 64));
      send_random(90);
      drain();
    end
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS text_console_char_statistics");
    end else begin
      $display("FAIL text_console_char_statistics");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIME_LIMIT);
    $display("FAIL text_console_char_statistics");
    $finish;
  end

endmodule
